// ----- sv/wlsa_pkg.sv -----
// Package for the windowed line snap aligner: shared types, codes and sizes.
// No dependencies.
package wlsa_pkg;

  localparam int unsigned DefMaxWidth  = 640;
  localparam int unsigned DefMaxHeight = 480;
  localparam int unsigned DefMaxWindow = 32;

  localparam int unsigned CmdW = 2;
  localparam int unsigned PixW = 8;
  localparam int unsigned CntW = 10;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 10;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_AXIS   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN_INIT,
    ST_CNT_RD,
    ST_CNT_ACC,
    ST_BEST,
    ST_TARGET,
    ST_MOV_RD,
    ST_MOV_WR,
    ST_NEXT_WIN,
    ST_READ_WAIT,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;      // write pixel_in at load pointer
    logic read_rd;      // issue a frame read at read pointer
    logic read_cap;     // capture read data into output register
    logic run_init;     // start alignment at window 0
    logic win_init;     // clear counters, set ln to window start
    logic cnt_rd;       // read pixel (ln,cr) for counting
    logic cnt_acc;      // accumulate and advance counting position
    logic best_step;    // scan one counter
    logic tgt_calc;     // compute target line
    logic mov_rd;       // read pixel (ln,cr) for moving
    logic mov_wr;       // write target and zero source, advance
    logic next_win;     // advance window start
    logic ptr_reset;    // zero both pointers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_done;     // last pixel of window counted
    logic best_done;    // last counter scanned
    logic found;        // a nonzero count exists
    logic tgt_ok;       // target within frame
    logic mov_done;     // last pixel of window moved
    logic run_done;     // no more windows
  } sts_t;

endpackage

// ----- sv/wlsa_datapath.sv -----
// Datapath of the windowed line snap aligner: frame memory, residue counters,
// pointers and window walk. Depends on wlsa_pkg.
module wlsa_datapath import wlsa_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned MaxWindow = DefMaxWindow
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [PixW-1:0] pixel_in_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic [PixW-1:0] pixel_out_o,
  output logic            last_pixel_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MaxWidth + 1);
  localparam int unsigned YW    = $clog2(MaxHeight + 1);
  localparam int unsigned LW    = (XW > YW) ? XW : YW;
  localparam int unsigned WW    = $clog2(MaxWindow + 1);
  localparam int unsigned RW    = $clog2(MaxWindow);

  // configuration registers
  logic [5:0] win_q;
  logic       axis_q;
  logic [9:0] width_q;
  logic [8:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= 6'd8;
      axis_q   <= 1'b0;
      width_q  <= 10'd640;
      height_q <= 9'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_WINDOW: win_q    <= cfg_data_i[5:0];
        CFG_AXIS:   axis_q   <= cfg_data_i[0];
        CFG_WIDTH:  width_q  <= cfg_data_i[9:0];
        CFG_HEIGHT: height_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [LW-1:0] w_eff, h_eff, n_lines, n_cross;
  logic [WW-1:0] ws;
  logic [AW:0]   total;
  always_comb begin
    if (width_q == '0) w_eff = LW'(1);
    else if (32'(width_q) > MaxWidth) w_eff = LW'(MaxWidth);
    else w_eff = LW'(width_q);
    if (height_q == '0) h_eff = LW'(1);
    else if (32'(height_q) > MaxHeight) h_eff = LW'(MaxHeight);
    else h_eff = LW'(height_q);
    if (win_q < 6'd2) ws = WW'(2);
    else if (32'(win_q) > MaxWindow) ws = WW'(MaxWindow);
    else ws = WW'(win_q);
    n_lines = axis_q ? h_eff : w_eff;
    n_cross = axis_q ? w_eff : h_eff;
  end

  // total pixel count, follows the size registers directly
  assign total = (AW+1)'(w_eff * h_eff);

  // window walk registers
  logic [LW-1:0] s_q, ln_q, cr_q, end_q, tgt_q;
  logic [RW-1:0] res_q;      // ln mod ws, tracked incrementally
  logic [RW-1:0] s_res_q;    // s mod ws
  logic [RW-1:0] m_q, best_q;
  logic [CntW-1:0] best_cnt_q;
  logic          found_q;
  logic [CntW-1:0] cnt_q [MaxWindow];

  logic [AW-1:0] ld_ptr_q, rd_ptr_q;
  logic [AW-1:0] ld_cur, rd_cur;

  // an out-of-range pointer restarts at 0 before use
  assign ld_cur = ((AW+1)'(ld_ptr_q) >= total) ? '0 : ld_ptr_q;
  assign rd_cur = ((AW+1)'(rd_ptr_q) >= total) ? '0 : rd_ptr_q;

  // pixel address of (ln, cr); reads use it directly, addr_q and tgt_addr_q register it
  logic [AW-1:0] addr_q, tgt_addr_q;
  logic [AW-1:0] addr_d, tgt_addr_d;
  always_comb begin
    if (axis_q) begin
      addr_d     = AW'(ln_q * w_eff + cr_q);
      tgt_addr_d = AW'(tgt_q * w_eff + cr_q);
    end else begin
      addr_d     = AW'(cr_q * w_eff + ln_q);
      tgt_addr_d = AW'(cr_q * w_eff + tgt_q);
    end
  end

  // frame memory
  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;
  logic [AW-1:0]   wr_addr;
  logic [PixW-1:0] wr_data;
  logic            wr_en;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;

  // pixels on the target line are walked but left alone
  logic mov_act;
  assign mov_act = cmd_i.mov_wr && rdata_q != '0 && ln_q != tgt_q;

  always_comb begin
    wr_en = 1'b0; wr_addr = ld_cur; wr_data = pixel_in_i;
    if (cmd_i.load_wr) begin
      wr_en = 1'b1;
    end else if (mov_act) begin
      wr_en = 1'b1; wr_addr = tgt_addr_q; wr_data = rdata_q;
    end
    rd_en   = cmd_i.read_rd | cmd_i.cnt_rd | cmd_i.mov_rd;
    rd_addr = cmd_i.read_rd ? rd_cur : addr_d;
  end

  // the source is zeroed the cycle after its target is written
  logic          zero_pend_q;
  logic [AW-1:0] zero_addr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zero_pend_q <= 1'b0;
    else zero_pend_q <= mov_act;
  end
  always_ff @(posedge clk_i) zero_addr_q <= addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    else if (zero_pend_q) mem[zero_addr_q] <= '0;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    tgt_addr_q <= tgt_addr_d;
  end

  // pointers
  logic [AW:0] ld_nx, rd_nx;
  logic        rd_last;
  assign ld_nx   = (AW+1)'(ld_cur) + 1'b1;
  assign rd_nx   = (AW+1)'(rd_cur) + 1'b1;
  assign rd_last = (rd_nx == total);
  logic rd_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_ptr_q <= '0;
      rd_ptr_q <= '0;
      rd_last_q <= 1'b0;
    end else begin
      if (cmd_i.ptr_reset) begin
        ld_ptr_q <= '0;
        rd_ptr_q <= '0;
      end
      if (cmd_i.load_wr) ld_ptr_q <= (ld_nx >= total) ? '0 : AW'(ld_nx);
      if (cmd_i.read_rd) begin
        rd_ptr_q  <= (rd_nx >= total) ? '0 : AW'(rd_nx);
        rd_last_q <= rd_last;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_cap) begin
      pixel_out_o  <= rdata_q;
      last_pixel_o <= rd_last_q;
    end
  end

  // window walk
  logic last_cr, last_ln;
  logic [LW:0] end_calc;
  assign last_cr  = (cr_q + 1'b1 == n_cross);
  assign last_ln  = (ln_q + 1'b1 == end_q);
  assign end_calc = (LW+1)'(s_q) + (LW+1)'(ws);
  logic [RW:0] res_inc;
  assign res_inc = (RW+1)'(res_q) + 1'b1;
  logic [LW:0] s_nx;
  assign s_nx = (LW+1)'(s_q) + (LW+1)'(ws >> 1);
  logic [RW:0] sres_nx;
  always_comb begin
    sres_nx = (RW+1)'(s_res_q) + (RW+1)'(ws >> 1);
    if (sres_nx >= (RW+1)'(ws)) sres_nx = sres_nx - (RW+1)'(ws);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0; ln_q <= '0; cr_q <= '0; end_q <= '0; tgt_q <= '0;
      res_q <= '0; s_res_q <= '0; m_q <= '0; best_q <= '0;
      best_cnt_q <= '0; found_q <= 1'b0;
      for (int i = 0; i < MaxWindow; i++) cnt_q[i] <= '0;
    end else begin
      if (cmd_i.run_init) begin
        s_q <= '0; s_res_q <= '0;
      end
      if (cmd_i.win_init) begin
        ln_q <= s_q; cr_q <= '0; res_q <= s_res_q; m_q <= '0;
        best_q <= '0; best_cnt_q <= '0; found_q <= 1'b0;
        end_q <= (end_calc > (LW+1)'(n_lines)) ? n_lines : LW'(end_calc);
        for (int i = 0; i < MaxWindow; i++) cnt_q[i] <= '0;
      end
      if (cmd_i.cnt_acc || cmd_i.mov_wr) begin
        if (cmd_i.cnt_acc && rdata_q != '0) cnt_q[res_q] <= cnt_q[res_q] + 1'b1;
        if (last_cr) begin
          cr_q <= '0;
          if (last_ln) begin
            ln_q <= s_q; res_q <= s_res_q;
          end else begin
            ln_q <= ln_q + 1'b1;
            res_q <= (res_inc >= (RW+1)'(ws)) ? '0 : RW'(res_inc);
          end
        end else cr_q <= cr_q + 1'b1;
      end
      if (cmd_i.best_step) begin
        if (cnt_q[m_q] > best_cnt_q) begin
          best_cnt_q <= cnt_q[m_q]; best_q <= m_q; found_q <= 1'b1;
        end
        m_q <= m_q + 1'b1;
      end
      if (cmd_i.tgt_calc) begin
        if (best_q < s_res_q) tgt_q <= LW'(s_q + best_q + (ws - s_res_q));
        else tgt_q <= LW'(s_q + (best_q - s_res_q));
      end
      if (cmd_i.next_win) begin
        s_q <= LW'(s_nx); s_res_q <= RW'(sres_nx);
      end
    end
  end

  assign sts_o.cnt_done  = last_cr && last_ln;
  assign sts_o.best_done = ((RW+1)'(m_q) + 1'b1 == (RW+1)'(ws));
  assign sts_o.found     = found_q;
  assign sts_o.tgt_ok    = tgt_q < n_lines;
  assign sts_o.mov_done  = last_cr && last_ln;
  assign sts_o.run_done  = s_nx >= (LW+1)'(n_lines);

endmodule

// ----- sv/wlsa_ctrl.sv -----
// Controller of the windowed line snap aligner: handshake and sequencing.
// Depends on wlsa_pkg.
module wlsa_ctrl import wlsa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CmdW-1:0] cmd_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  state_e st_q, st_d;
  logic   acc;
  logic   out_take;

  assign out_take   = out_valid_o && !out_stall_i;
  assign in_stall_o = !(st_q == ST_IDLE || (st_q == ST_OUT && out_take));
  assign acc        = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE, ST_OUT: begin
        if (st_q == ST_OUT && !out_take) st_d = ST_OUT;
        else if (acc && cmd_e'(cmd_i) == CMD_RUN) st_d = ST_WIN_INIT;
        else if (acc && cmd_e'(cmd_i) == CMD_READ) st_d = ST_READ_WAIT;
        else st_d = ST_IDLE;
      end
      ST_READ_WAIT: st_d = ST_OUT;
      ST_WIN_INIT:  st_d = ST_CNT_RD;
      ST_CNT_RD:    st_d = ST_CNT_ACC;
      ST_CNT_ACC:   st_d = sts_i.cnt_done ? ST_BEST : ST_CNT_RD;
      ST_BEST:      st_d = sts_i.best_done ? ST_TARGET : ST_BEST;
      ST_TARGET:    st_d = ST_MOV_RD;
      ST_MOV_RD:    st_d = (!sts_i.found || !sts_i.tgt_ok) ? ST_NEXT_WIN : ST_MOV_WR;
      ST_MOV_WR:    st_d = sts_i.mov_done ? ST_NEXT_WIN : ST_MOV_RD;
      ST_NEXT_WIN:  st_d = sts_i.run_done ? ST_IDLE : ST_WIN_INIT;
      default:      st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.load_wr   = acc && cmd_e'(cmd_i) == CMD_LOAD;
    cmd_o.read_rd   = acc && cmd_e'(cmd_i) == CMD_READ;
    cmd_o.run_init  = acc && cmd_e'(cmd_i) == CMD_RUN;
    cmd_o.ptr_reset = acc && cmd_e'(cmd_i) == CMD_RUN;
    cmd_o.read_cap  = st_q == ST_READ_WAIT;
    cmd_o.win_init  = st_q == ST_WIN_INIT;
    cmd_o.cnt_rd    = st_q == ST_CNT_RD;
    cmd_o.cnt_acc   = st_q == ST_CNT_ACC;
    cmd_o.best_step = st_q == ST_BEST;
    cmd_o.tgt_calc  = st_q == ST_TARGET;
    cmd_o.mov_rd    = st_q == ST_MOV_RD;
    cmd_o.mov_wr    = st_q == ST_MOV_WR;
    cmd_o.next_win  = st_q == ST_NEXT_WIN;
  end

  assign out_valid_o = st_q == ST_OUT;

  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE && st_q != ST_OUT) |-> in_stall_o) else $error("accept while busy");
  ap_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read_rd |=> st_q == ST_READ_WAIT ##1 out_valid_o) else $error("read lost");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");

endmodule

// ----- sv/windowed_line_snap_aligner_core.sv -----
// Channel  | handshake          | payload
// in       | in_valid/in_stall  | cmd_i, pixel_in_i
// out      | out_valid/out_stall| pixel_out_o, last_pixel_o
// cfg      | cfg_we_i           | cfg_idx_i, cfg_data_i
// A load item is written as it is taken; a read result is offered once it has
// passed the memory read and the output register.
// Run counts, then moves, each window through the single frame memory: read and
// accumulate per pixel, a scan of window_size counters, a target step, read and
// write per pixel; an empty window skips the move pass after a probe read.
// Reset clears control and sets the configuration to its defaults; the frame memory is not cleared.
// A stalled result holds, and no item is taken until it leaves.
module windowed_line_snap_aligner_core import wlsa_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned MaxWindow = DefMaxWindow
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [PixW-1:0]     pixel_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     pixel_out_o,
  output logic                last_pixel_o
);

  cmd_t cmd;
  sts_t sts;

  wlsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i,
    .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  wlsa_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxWindow(MaxWindow)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .pixel_in_i,
    .cmd_i(cmd), .sts_o(sts), .pixel_out_o, .last_pixel_o
  );

endmodule
